>>> rtl/pcps_pkg.sv
// shared codes, datapath command and status types for the polyline closest point block
package pcps_pkg;

	// input command codes
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FEW  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// side codes
	localparam logic signed [1:0] SIDE_ZERO = 2'sb00;
	localparam logic signed [1:0] SIDE_POS  = 2'sb01;
	localparam logic signed [1:0] SIDE_NEG  = 2'sb11;

	// iteration counts of the divider and the square root
	localparam int DIV_STEPS  = 33;
	localparam int SQRT_STEPS = 32;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD_IN,
		OP_APPEND,
		OP_CLEAR,
		OP_FEW,
		OP_READ,
		OP_FIRST,
		OP_SEG,
		OP_M_BXBX,
		OP_M_BYBY,
		OP_M_AXBX,
		OP_M_AYBY,
		OP_DOT,
		OP_C_X0,
		OP_C_X1,
		OP_P_LO,
		OP_P_HI,
		OP_P_NUM,
		OP_DIV,
		OP_P_END,
		OP_E,
		OP_M_EXEX,
		OP_M_EYEY,
		OP_D2,
		OP_BEST,
		OP_SIDE_E,
		OP_M_EXBBY,
		OP_M_EYBBX,
		OP_SIDE,
		OP_SQ,
		OP_FIN,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   axis;
		logic   first;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       few;
		logic       low;
		logic       ge;
		logic       last;
		logic       out_busy;
	} dp_stat_t;

endpackage

>>> rtl/pcps_in_if.sv
// input channel: command and point coordinates
interface pcps_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic signed [31:0] px;
	logic signed [31:0] py;

	modport source (output valid, cmd, px, py, input ready);
	modport sink (input valid, cmd, px, py, output ready);
endinterface

>>> rtl/pcps_out_if.sv
// result channel: status, distance, closest point and side
interface pcps_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [31:0]        distance;
	logic signed [31:0] closest_x;
	logic signed [31:0] closest_y;
	logic signed [1:0]  side;

	modport source (output valid, status, distance, closest_x, closest_y, side, input ready);
	modport sink (input valid, status, distance, closest_x, closest_y, side, output ready);
endinterface

>>> rtl/polyline_closest_point_side_top.sv
// top level of the polyline closest point and side block
//
// in_ch carries one command beat: append a vertex (cmd 0), query a point (cmd 1)
// or clear the polyline (cmd 2), with a signed Q16.16 point in px, py.
// out_ch returns exactly one result beat per input beat, in order: status,
// distance (unsigned Q16.16, saturated), closest point and side (+1, -1, 0).
// One beat is worked on at a time; in_ch.ready is high while the controller idles.
// A query walks the segments in turn; a segment onto which the point does not
// project skips the projection. Each projected segment is dominated by the
// radix-2 divider, run once per coordinate, and the result by the 32-step
// square root; the shared 35x35 multiplier does one product a cycle.
// Reset empties the polyline (vertex memory contents are left as they are)
// and drops any pending result. A stalled receiver holds the result register;
// the next beat is accepted and worked on meanwhile and waits only to deliver.
module polyline_closest_point_side_top #(
	parameter int MAX_VERTICES = 64
) (
	input logic        clk,
	input logic        arst_n,
	pcps_in_if.sink    in_ch,
	pcps_out_if.source out_ch
);
	import pcps_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	dp_cmd_t       dp_cmd;
	dp_stat_t      dp_stat;
	logic [AW-1:0] dp_addr;

	// controller
	pcps_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd),
		.addr     (dp_addr)
	);

	// datapath
	pcps_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.addr          (dp_addr),
		.stat          (dp_stat),
		.in_cmd        (in_ch.cmd),
		.in_px         (in_ch.px),
		.in_py         (in_ch.py),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_status    (out_ch.status),
		.out_distance  (out_ch.distance),
		.out_closest_x (out_ch.closest_x),
		.out_closest_y (out_ch.closest_y),
		.out_side      (out_ch.side)
	);

	// one beat in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input accepted while a beat is in flight");

	// side code is never the unused pattern
	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.side != 2'sb10)
		else $error("invalid side code");

	// results with a non-ok status carry zero distance and a zero side
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status != ST_OK |->
			out_ch.distance == '0 && out_ch.side == SIDE_ZERO)
		else $error("error result carries distance or side");

endmodule

>>> rtl/pcps_datapath.sv
// datapath: vertex memory, shared multiplier, divider, square root and result register
module pcps_datapath #(
	parameter int MAX_VERTICES = 64,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
	localparam int CW = $clog2(MAX_VERTICES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pcps_pkg::dp_cmd_t  cmd,
	input  logic [AW-1:0]      addr,
	output pcps_pkg::dp_stat_t stat,
	input  logic [1:0]         in_cmd,
	input  logic signed [31:0] in_px,
	input  logic signed [31:0] in_py,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_status,
	output logic [31:0]        out_distance,
	output logic signed [31:0] out_closest_x,
	output logic signed [31:0] out_closest_y,
	output logic signed [1:0]  out_side
);
	import pcps_pkg::*;

	logic [1:0]         cmd_q;
	logic signed [31:0] px_q, py_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] mem_x [MAX_VERTICES];
	logic signed [31:0] mem_y [MAX_VERTICES];
	logic signed [31:0] rdx_q, rdy_q;
	logic signed [31:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [32:0] bx_q, by_q, ax_q, ay_q, ex_q, ey_q;
	logic signed [69:0] prod_q, acc_q, dot_q;
	logic [65:0]        magb_q, d2_q, best_q;
	logic signed [31:0] cx_q, cy_q, bcx_q, bcy_q;
	logic signed [32:0] bbx_q, bby_q;
	logic [65:0]        rem_q;
	logic [32:0]        numlo_q, quo_q;
	logic [63:0]        sv_q;
	logic [31:0]        root_q;
	logic [35:0]        srem_q;
	logic [1:0]         status_q;
	logic [31:0]        dist_q;
	logic signed [31:0] rcx_q, rcy_q;
	logic signed [1:0]  side_q;
	logic               ovalid_q;

	logic               full;
	logic               dot_pos;
	logic signed [32:0] b_axis;
	logic [32:0]        b_mag;
	logic signed [34:0] ma, mb;
	logic signed [69:0] mprod;
	logic [98:0]        num;
	logic [66:0]        r2;
	logic               div_ge;
	logic               rnd;
	logic [32:0]        qf;
	logic signed [33:0] qs, csum;
	logic signed [31:0] base;
	logic [35:0]        sq_t, sq_trial;

	// status back to the controller
	assign full    = (count_q == CW'(MAX_VERTICES));
	assign dot_pos = !dot_q[69] && (dot_q != '0);
	always_comb begin
		stat.cmd      = cmd_q;
		stat.few      = (count_q < CW'(2));
		stat.low      = (magb_q == '0) || !dot_pos;
		stat.ge       = (dot_q[65:0] >= magb_q);
		stat.last     = ((CW'(addr) + CW'(1)) == count_q);
		stat.out_busy = ovalid_q && !out_ready;
	end

	// segment direction magnitude on the axis being projected
	assign b_axis = cmd.axis ? by_q : bx_q;
	assign b_mag  = b_axis[32] ? 33'(-b_axis) : 33'(b_axis);

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_M_BXBX: begin ma = 35'(bx_q); mb = 35'(bx_q); end
			OP_M_BYBY: begin ma = 35'(by_q); mb = 35'(by_q); end
			OP_M_AXBX: begin ma = 35'(ax_q); mb = 35'(bx_q); end
			OP_M_AYBY: begin ma = 35'(ay_q); mb = 35'(by_q); end
			OP_P_LO: begin
				ma = $signed({3'b0, dot_q[31:0]});
				mb = $signed({2'b0, b_mag});
			end
			OP_P_HI: begin
				ma = $signed({1'b0, dot_q[65:32]});
				mb = $signed({2'b0, b_mag});
			end
			OP_M_EXEX:  begin ma = 35'(ex_q); mb = 35'(ex_q); end
			OP_M_EYEY:  begin ma = 35'(ey_q); mb = 35'(ey_q); end
			OP_M_EXBBY: begin ma = 35'(ex_q); mb = 35'(bby_q); end
			OP_M_EYBBX: begin ma = 35'(ey_q); mb = 35'(bbx_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign mprod = ma * mb;

	// projection numerator, divider step and rounding
	assign num      = {33'b0, acc_q[65:0]} + {prod_q[66:0], 32'b0};
	assign r2       = {rem_q, numlo_q[32]};
	assign div_ge   = (r2 >= {1'b0, magb_q});
	assign rnd      = ({rem_q, 1'b0} >= {1'b0, magb_q});
	assign qf       = quo_q + 33'(rnd);
	assign qs       = $signed({1'b0, qf});
	assign base     = cmd.axis ? y0_q : x0_q;
	assign csum     = 34'(base) + (b_axis[32] ? -qs : qs);

	// square root digit step
	assign sq_t     = {srem_q[33:0], sv_q[63:62]};
	assign sq_trial = {2'b0, root_q, 2'b01};

	// vertex memory
	always_ff @(posedge clk) begin
		if (cmd.op == OP_APPEND && !full) begin
			mem_x[count_q[AW-1:0]] <= px_q;
			mem_y[count_q[AW-1:0]] <= py_q;
		end
		if (cmd.op == OP_READ) begin
			rdx_q <= mem_x[addr];
			rdy_q <= mem_y[addr];
		end
	end

	// vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			count_q <= '0;
		end else if (cmd.op == OP_APPEND && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD_IN: begin
				cmd_q    <= in_cmd;
				px_q     <= in_px;
				py_q     <= in_py;
				status_q <= ST_OK;
				dist_q   <= '0;
				rcx_q    <= '0;
				rcy_q    <= '0;
				side_q   <= SIDE_ZERO;
			end
			OP_APPEND: begin
				if (full) begin
					status_q <= ST_FULL;
				end
			end
			OP_FEW: status_q <= ST_FEW;
			OP_FIRST: begin
				x1_q <= rdx_q;
				y1_q <= rdy_q;
			end
			OP_SEG: begin
				x0_q <= x1_q;
				y0_q <= y1_q;
				x1_q <= rdx_q;
				y1_q <= rdy_q;
				bx_q <= 33'(rdx_q) - 33'(x1_q);
				by_q <= 33'(rdy_q) - 33'(y1_q);
				ax_q <= 33'(px_q) - 33'(x1_q);
				ay_q <= 33'(py_q) - 33'(y1_q);
			end
			OP_M_BXBX: prod_q <= mprod;
			OP_M_BYBY: begin
				prod_q <= mprod;
				acc_q  <= prod_q;
			end
			OP_M_AXBX: begin
				prod_q <= mprod;
				magb_q <= acc_q[65:0] + prod_q[65:0];
			end
			OP_M_AYBY: begin
				prod_q <= mprod;
				acc_q  <= prod_q;
			end
			OP_DOT: dot_q <= acc_q + prod_q;
			OP_C_X0: begin
				cx_q <= x0_q;
				cy_q <= y0_q;
			end
			OP_C_X1: begin
				cx_q <= x1_q;
				cy_q <= y1_q;
			end
			OP_P_LO: prod_q <= mprod;
			OP_P_HI: begin
				prod_q <= mprod;
				acc_q  <= prod_q;
			end
			OP_P_NUM: begin
				rem_q   <= num[98:33];
				numlo_q <= num[32:0];
				quo_q   <= '0;
			end
			OP_DIV: begin
				rem_q   <= div_ge ? 66'(r2 - {1'b0, magb_q}) : r2[65:0];
				quo_q   <= {quo_q[31:0], div_ge};
				numlo_q <= {numlo_q[31:0], 1'b0};
			end
			OP_P_END: begin
				if (cmd.axis) begin
					cy_q <= csum[31:0];
				end else begin
					cx_q <= csum[31:0];
				end
			end
			OP_E: begin
				ex_q <= 33'(px_q) - 33'(cx_q);
				ey_q <= 33'(py_q) - 33'(cy_q);
			end
			OP_M_EXEX: prod_q <= mprod;
			OP_M_EYEY: begin
				prod_q <= mprod;
				acc_q  <= prod_q;
			end
			OP_D2: d2_q <= acc_q[65:0] + prod_q[65:0];
			OP_BEST: begin
				if (cmd.first || d2_q < best_q) begin
					best_q <= d2_q;
					bcx_q  <= cx_q;
					bcy_q  <= cy_q;
					bbx_q  <= bx_q;
					bby_q  <= by_q;
				end
			end
			OP_SIDE_E: begin
				ex_q <= 33'(px_q) - 33'(bcx_q);
				ey_q <= 33'(py_q) - 33'(bcy_q);
			end
			OP_M_EXBBY: prod_q <= mprod;
			OP_M_EYBBX: begin
				prod_q <= mprod;
				acc_q  <= prod_q;
			end
			OP_SIDE: begin
				if (acc_q < prod_q) begin
					side_q <= SIDE_POS;
				end else if (acc_q > prod_q) begin
					side_q <= SIDE_NEG;
				end else begin
					side_q <= SIDE_ZERO;
				end
				sv_q   <= best_q[63:0];
				root_q <= '0;
				srem_q <= '0;
			end
			OP_SQ: begin
				if (sq_t >= sq_trial) begin
					srem_q <= sq_t - sq_trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= sq_t;
					root_q <= {root_q[30:0], 1'b0};
				end
				sv_q <= {sv_q[61:0], 2'b00};
			end
			OP_FIN: begin
				dist_q <= (best_q[65:64] != 2'b00) ? 32'hFFFF_FFFF : root_q;
				rcx_q  <= bcx_q;
				rcy_q  <= bcy_q;
			end
			default: begin
			end
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			out_status    <= status_q;
			out_distance  <= dist_q;
			out_closest_x <= rcx_q;
			out_closest_y <= rcy_q;
			out_side      <= side_q;
		end
	end

	assign out_valid = ovalid_q;

endmodule

>>> rtl/pcps_ctrl.sv
// controller: sequences appends, clears and the per-segment query steps
module pcps_ctrl #(
	parameter int MAX_VERTICES = 64,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pcps_pkg::dp_stat_t stat,
	output pcps_pkg::dp_cmd_t  cmd,
	output logic [AW-1:0]      addr
);
	import pcps_pkg::*;

	typedef enum logic [20:0] {
		S_IDLE   = 21'd1 << 0,
		S_DISP   = 21'd1 << 1,
		S_FIRST  = 21'd1 << 2,
		S_RD     = 21'd1 << 3,
		S_SEG    = 21'd1 << 4,
		S_MUL    = 21'd1 << 5,
		S_DOT    = 21'd1 << 6,
		S_DECIDE = 21'd1 << 7,
		S_PROJ   = 21'd1 << 8,
		S_DIV    = 21'd1 << 9,
		S_PEND   = 21'd1 << 10,
		S_E      = 21'd1 << 11,
		S_DM     = 21'd1 << 12,
		S_D2     = 21'd1 << 13,
		S_BEST   = 21'd1 << 14,
		S_SIDE   = 21'd1 << 15,
		S_SM     = 21'd1 << 16,
		S_SIDEC  = 21'd1 << 17,
		S_SQ     = 21'd1 << 18,
		S_FIN    = 21'd1 << 19,
		S_OUT    = 21'd1 << 20
	} state_t;

	state_t        state_q, state_d;
	logic [5:0]    step_q, step_d;
	logic [AW-1:0] idx_q, idx_d;
	logic          axis_q, axis_d;

	assign in_ready = (state_q == S_IDLE);
	assign addr     = (state_q == S_DISP) ? '0 : idx_q;

	// next state and datapath command
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		idx_d     = idx_q;
		axis_d    = axis_q;
		cmd.op    = OP_NONE;
		cmd.axis  = axis_q;
		cmd.first = (idx_q == AW'(1));
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD_IN;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.cmd)
					CMD_APPEND: begin
						cmd.op  = OP_APPEND;
						state_d = S_OUT;
					end
					CMD_CLEAR: begin
						cmd.op  = OP_CLEAR;
						state_d = S_OUT;
					end
					CMD_QUERY: begin
						if (stat.few) begin
							cmd.op  = OP_FEW;
							state_d = S_OUT;
						end else begin
							cmd.op  = OP_READ;
							idx_d   = AW'(1);
							state_d = S_FIRST;
						end
					end
					default: state_d = S_OUT;
				endcase
			end
			S_FIRST: begin
				cmd.op  = OP_FIRST;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.op  = OP_READ;
				state_d = S_SEG;
			end
			S_SEG: begin
				cmd.op  = OP_SEG;
				step_d  = '0;
				state_d = S_MUL;
			end
			S_MUL: begin
				case (step_q[1:0])
					2'd0: cmd.op = OP_M_BXBX;
					2'd1: cmd.op = OP_M_BYBY;
					2'd2: cmd.op = OP_M_AXBX;
					default: cmd.op = OP_M_AYBY;
				endcase
				step_d = step_q + 6'd1;
				if (step_q == 6'd3) begin
					state_d = S_DOT;
				end
			end
			S_DOT: begin
				cmd.op  = OP_DOT;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.low) begin
					cmd.op  = OP_C_X0;
					state_d = S_E;
				end else if (stat.ge) begin
					cmd.op  = OP_C_X1;
					state_d = S_E;
				end else begin
					axis_d  = 1'b0;
					step_d  = '0;
					state_d = S_PROJ;
				end
			end
			S_PROJ: begin
				case (step_q[1:0])
					2'd0: cmd.op = OP_P_LO;
					2'd1: cmd.op = OP_P_HI;
					default: cmd.op = OP_P_NUM;
				endcase
				step_d = step_q + 6'd1;
				if (step_q == 6'd2) begin
					step_d  = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				step_d = step_q + 6'd1;
				if (step_q == 6'(DIV_STEPS - 1)) begin
					state_d = S_PEND;
				end
			end
			S_PEND: begin
				cmd.op = OP_P_END;
				step_d = '0;
				if (axis_q) begin
					state_d = S_E;
				end else begin
					axis_d  = 1'b1;
					state_d = S_PROJ;
				end
			end
			S_E: begin
				cmd.op  = OP_E;
				step_d  = '0;
				state_d = S_DM;
			end
			S_DM: begin
				cmd.op = step_q[0] ? OP_M_EYEY : OP_M_EXEX;
				step_d = step_q + 6'd1;
				if (step_q[0]) begin
					state_d = S_D2;
				end
			end
			S_D2: begin
				cmd.op  = OP_D2;
				state_d = S_BEST;
			end
			S_BEST: begin
				cmd.op = OP_BEST;
				if (stat.last) begin
					state_d = S_SIDE;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = S_RD;
				end
			end
			S_SIDE: begin
				cmd.op  = OP_SIDE_E;
				step_d  = '0;
				state_d = S_SM;
			end
			S_SM: begin
				cmd.op = step_q[0] ? OP_M_EYBBX : OP_M_EXBBY;
				step_d = step_q + 6'd1;
				if (step_q[0]) begin
					state_d = S_SIDEC;
				end
			end
			S_SIDEC: begin
				cmd.op  = OP_SIDE;
				step_d  = '0;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = OP_SQ;
				step_d = step_q + 6'd1;
				if (step_q == 6'(SQRT_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			idx_q   <= '0;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			idx_q   <= idx_d;
			axis_q  <= axis_d;
		end
	end

endmodule

>>> dv/tb.sv
// self-checking testbench of the polyline closest point and side block
`timescale 1ns / 100ps

module tb;
	import pcps_pkg::*;

	localparam int NVERT = 64;
	localparam longint CYCLE_LIMIT = 64'd20000000;
	// command code with no function
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]         status;
		logic [31:0]        distance;
		logic signed [31:0] closest_x;
		logic signed [31:0] closest_y;
		logic signed [1:0]  side;
	} nearest_t;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [31:0] px;
		logic signed [31:0] py;
		bit                 typed;
		logic [1:0]         status;
	} row_t;

	logic clk;
	logic arst_n;
	pcps_in_if  in_ch();
	pcps_out_if out_ch();

	polyline_closest_point_side_top #(.MAX_VERTICES(NVERT)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	// polyline copy used for prediction
	logic signed [31:0] poly_x [NVERT];
	logic signed [31:0] poly_y [NVERT];
	int poly_len;

	nearest_t   pending_results[$];
	int         errors;
	longint     cycles;
	int         send_idle_pct;
	int         recv_idle_pct;

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("polyline_closest_point_side_top regression: fail");
			$finish;
		end
	end

	// round(dm * |b| / den), half away from zero, sign of b
	function automatic logic signed [63:0] round_project(logic [127:0] dm,
			logic signed [63:0] b, logic [127:0] den);
		logic [63:0]  mb;
		logic [127:0] num;
		logic [127:0] q;
		logic [127:0] r;
		mb = b < 0 ? 64'(-b) : 64'(b);
		if (mb == 0) return 0;
		num = dm * mb;
		q = num / den;
		r = num % den;
		if ((r << 1) >= den) q = q + 1;
		return b < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic [31:0] floor_sqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int k = 31; k >= 0; k--) begin
			c = r | (64'd1 << k);
			if (c * c <= v) r = c;
		end
		return r[31:0];
	endfunction

	// nearest point predictor, updates the polyline copy
	function automatic nearest_t nearest_step(logic [1:0] cmd, logic signed [31:0] qx,
			logic signed [31:0] qy);
		nearest_t res;
		logic signed [63:0] x0, y0, x1, y1, bx, by, cx, cy, ex, ey, px, py;
		logic signed [63:0] bcx, bcy, bbx, bby;
		logic [127:0] magb, d2, best;
		logic signed [129:0] dot, lhs, rhs;
		res = '{default: '0};
		px = qx; py = qy;
		bcx = 0; bcy = 0; bbx = 0; bby = 0; best = 0;
		case (cmd)
			CMD_APPEND: begin
				if (poly_len >= NVERT) res.status = ST_FULL;
				else begin
					poly_x[poly_len] = qx;
					poly_y[poly_len] = qy;
					poly_len++;
				end
				return res;
			end
			CMD_CLEAR: begin
				poly_len = 0;
				return res;
			end
			CMD_QUERY: ;
			default: return res;
		endcase
		if (poly_len < 2) begin
			res.status = ST_FEW;
			return res;
		end
		for (int i = 1; i < poly_len; i++) begin
			x0 = poly_x[i-1]; y0 = poly_y[i-1];
			x1 = poly_x[i]; y1 = poly_y[i];
			bx = x1 - x0; by = y1 - y0;
			magb = 128'($signed(130'(bx) * 130'(bx))) + 128'($signed(130'(by) * 130'(by)));
			dot = 130'(px - x0) * 130'(bx) + 130'(py - y0) * 130'(by);
			if (magb == 0 || dot <= 0) begin
				cx = x0; cy = y0;
			end else if (128'(dot) >= magb) begin
				cx = x1; cy = y1;
			end else begin
				cx = x0 + round_project(128'(dot), bx, magb);
				cy = y0 + round_project(128'(dot), by, magb);
			end
			ex = px - cx; ey = py - cy;
			d2 = 128'($signed(130'(ex) * 130'(ex))) + 128'($signed(130'(ey) * 130'(ey)));
			if (i == 1 || d2 < best) begin
				best = d2; bcx = cx; bcy = cy; bbx = bx; bby = by;
			end
		end
		res.distance  = best[127:64] != 0 ? 32'hFFFF_FFFF : floor_sqrt(best[63:0]);
		res.closest_x = bcx[31:0];
		res.closest_y = bcy[31:0];
		lhs = 130'(px - bcx) * 130'(bby);
		rhs = 130'(py - bcy) * 130'(bbx);
		res.side = lhs < rhs ? SIDE_POS : (lhs > rhs ? SIDE_NEG : SIDE_ZERO);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
	endtask

	// send one command beat, queue its prediction; valid stays high until the
	// next beat or the end of the run takes it down
	task automatic send_beat(logic [1:0] cmd, logic signed [31:0] px,
			logic signed [31:0] py, bit typed = 0, logic [1:0] status = ST_OK);
		nearest_t exp_res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		exp_res = nearest_step(cmd, px, py);
		if (typed && exp_res.status != status)
			report_mismatch("typed status", 32'(exp_res.status), 32'(status));
		pending_results = {pending_results, exp_res};
		in_ch.valid <= 1'b1;
		in_ch.cmd   <= cmd;
		in_ch.px    <= px;
		in_ch.py    <= py;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// receiver: random stall and result check
	always @(posedge clk) begin
		nearest_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (pending_results.size() == 0)
					report_mismatch("unexpected beat", 32'(out_ch.status), 32'd0);
				else begin
					want = pending_results.pop_front();
					if (out_ch.status !== want.status)
						report_mismatch("status", 32'(out_ch.status), 32'(want.status));
					if (out_ch.distance !== want.distance)
						report_mismatch("distance", out_ch.distance, want.distance);
					if (out_ch.closest_x !== want.closest_x)
						report_mismatch("closest_x", out_ch.closest_x, want.closest_x);
					if (out_ch.closest_y !== want.closest_y)
						report_mismatch("closest_y", out_ch.closest_y, want.closest_y);
					if (out_ch.side !== want.side)
						report_mismatch("side", 32'(out_ch.side), 32'(want.side));
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return $signed($urandom());
			1: return $signed($urandom_range(2000000)) - 1000000;
			default: return $signed($urandom_range(400)) - 200;
		endcase
	endfunction

	// random traffic: polylines cleared, built up then queried, with occasional extra appends and unused commands
	task automatic random_phase(int n_items);
		int sent;
		int mode;
		int nv;
		sent = 0;
		while (sent < n_items) begin
			mode = $urandom_range(2);
			nv = $urandom_range(9) == 0 ? $urandom_range(NVERT + 2) : $urandom_range(6);
			send_beat(CMD_CLEAR, rand_coord(0), rand_coord(0));
			sent++;
			for (int k = 0; k < nv; k++) begin
				send_beat(CMD_APPEND, rand_coord(mode), rand_coord(mode));
				sent++;
			end
			for (int k = 0; k < $urandom_range(5, 1); k++) begin
				if ($urandom_range(9) == 0)
					send_beat(CMD_UNUSED, rand_coord(0), rand_coord(0));
				else if ($urandom_range(9) == 0)
					send_beat(CMD_APPEND, rand_coord(mode), rand_coord(mode));
				else
					send_beat(CMD_QUERY, rand_coord(mode), rand_coord(mode));
				sent++;
			end
		end
	endtask

	row_t directed_rows[$];

	initial begin
		errors = 0;
		cycles = 0;
		poly_len = 0;
		send_idle_pct = 15;
		recv_idle_pct = 70;
		in_ch.valid  = 1'b0;
		in_ch.cmd    = CMD_APPEND;
		in_ch.px     = '0;
		in_ch.py     = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: every row carries a typed status, checked against the prediction
		directed_rows = '{
			'{CMD_QUERY,  0, 0, 1, ST_FEW},
			'{CMD_APPEND, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, ST_OK},
			'{CMD_QUERY,  0, 0, 1, ST_FEW},
			'{CMD_APPEND, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, ST_OK},
			'{CMD_QUERY,  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, ST_OK},
			'{CMD_QUERY,  32'sh8000_0000, 32'sh8000_0000, 1, ST_OK},
			'{CMD_QUERY,  0, 0, 1, ST_OK},
			'{CMD_UNUSED, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1, ST_OK},
			'{CMD_CLEAR,  0, 0, 1, ST_OK},
			'{CMD_APPEND, 32'h0001_0000, 32'h0001_0000, 1, ST_OK},
			'{CMD_APPEND, 32'h0001_0000, 32'h0001_0000, 1, ST_OK},
			'{CMD_QUERY,  32'h0003_0000, 32'h0005_0000, 1, ST_OK},
			'{CMD_APPEND, 32'h0005_0000, 32'h0001_0000, 1, ST_OK},
			'{CMD_QUERY,  32'h0003_0000, 32'h0003_0000, 1, ST_OK},
			'{CMD_QUERY,  32'h0003_0000, 32'shFFFF_0000, 1, ST_OK},
			'{CMD_QUERY,  32'h0003_0000, 32'h0001_0000, 1, ST_OK},
			'{CMD_QUERY,  32'h0009_0000, 32'h0001_8000, 1, ST_OK},
			'{CMD_APPEND, 32'h0001_0000, 32'h0001_0000, 1, ST_OK},
			'{CMD_QUERY,  32'h0003_0000, 32'h0001_0000, 1, ST_OK},
			'{CMD_QUERY,  32'h0000_0003, 32'h0000_0007, 1, ST_OK},
			'{CMD_CLEAR,  0, 0, 1, ST_OK}
		};
		foreach (directed_rows[r])
			send_beat(directed_rows[r].cmd, directed_rows[r].px, directed_rows[r].py,
				directed_rows[r].typed, directed_rows[r].status);
		// fill the store to overflow
		for (int k = 0; k < NVERT + 1; k++)
			send_beat(CMD_APPEND, rand_coord(2), rand_coord(2), k == NVERT,
				k == NVERT ? ST_FULL : ST_OK);
		send_beat(CMD_QUERY, rand_coord(2), rand_coord(2));

		random_phase(180);
		send_idle_pct = 70;
		recv_idle_pct = 15;
		random_phase(180);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(150);
		in_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("polyline_closest_point_side_top regression: pass");
		else
			$display("polyline_closest_point_side_top regression: fail");
		$finish;
	end

endmodule
